// ===== rtl/vftc_pkg.sv =====
`default_nettype none
package vftc_pkg;

    localparam int unsigned RING_DEPTH = 256;

    localparam int unsigned TC_CELLS   = 4;
    localparam int unsigned OUT_BITS   = 152;

    typedef logic [7:0] t_bcd_pair;

    typedef struct packed {
        logic clear;
        logic inc;
    } t_cell_ctl;

    // frames, seconds, minutes, hours: last value before each field rolls over
    localparam t_bcd_pair TC_CELL_MAX [TC_CELLS] = '{8'h24, 8'h59, 8'h59, 8'h23};

    localparam logic [1:0] CFG_VIDEO_MODE    = 2'd0;
    localparam logic [1:0] CFG_TC_SELECT     = 2'd1;
    localparam logic [1:0] CFG_SOURCE_FRAMES = 2'd2;

    localparam logic [1:0] QUAL_LTC_ONLY  = 2'd1;
    localparam logic [1:0] QUAL_VITC_ONLY = 2'd2;

    localparam logic [2:0] MODE_PAL       = 3'd0;
    localparam logic [2:0] MODE_NTSC      = 3'd1;
    localparam logic [2:0] MODE_1080I25   = 3'd2;
    localparam logic [2:0] MODE_1080I2997 = 3'd3;
    localparam logic [2:0] MODE_1080I30   = 3'd4;
    localparam logic [2:0] MODE_720P50    = 3'd5;
    localparam logic [2:0] MODE_720P5994  = 3'd6;
    localparam logic [2:0] MODE_720P60    = 3'd7;

    // audio samples per frame * 2 channels * 4 bytes
    function automatic logic [13:0] vftc_audio_bytes(input logic [2:0] mode,
                                                     input logic [2:0] phase);
        logic [13:0] bytes;
        case (mode)
            MODE_NTSC, MODE_1080I2997: begin
                bytes = (phase == 3'd0) ? 14'd12800 : 14'd12816;
            end
            MODE_1080I30: begin
                bytes = 14'd12800;
            end
            MODE_720P50: begin
                bytes = 14'd7680;
            end
            MODE_720P5994: begin
                bytes = (phase == 3'd0 || phase == 3'd2) ? 14'd6416 : 14'd6400;
            end
            MODE_720P60: begin
                bytes = 14'd6400;
            end
            default: begin
                bytes = 14'd15360;
            end
        endcase
        return bytes;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/vftc_tc_cell.sv =====
`default_nettype none
module vftc_tc_cell
    import vftc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_bcd_pair i_max,
    output logic           o_carry,
    output t_bcd_pair      o_next
);

    t_bcd_pair r_val;
    t_bcd_pair n_val;
    logic      at_max;

    assign at_max  = (r_val == i_max);
    assign o_carry = i_ctl.inc && at_max;
    assign o_next  = n_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.clear) begin
            n_val = '0;
        end else if (i_ctl.inc) begin
            if (at_max) begin
                n_val = '0;
            end else if (r_val[3:0] == 4'd9) begin
                n_val = {r_val[7:4] + 4'd1, 4'd0};
            end else begin
                n_val = {r_val[7:4], r_val[3:0] + 4'd1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else begin
            r_val <= n_val;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/vftc_mod_unit.sv =====
`default_nettype none
module vftc_mod_unit
    import vftc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [8:0]  i_depth,
    output logic             o_busy,
    output logic             o_done,
    output logic [7:0]       o_rem
);

    logic       r_busy;
    logic [4:0] r_idx;
    logic [7:0] r_rem;
    logic       n_busy;
    logic [4:0] n_idx;
    logic [7:0] n_rem;
    logic [8:0] shifted;
    logic [8:0] reduced;

    // restoring remainder, one dividend bit per cycle, MSB first
    assign shifted = {r_rem, i_dividend[r_idx]};
    assign reduced = (shifted >= i_depth) ? shifted - i_depth : shifted;

    assign o_busy = r_busy;
    assign o_done = r_busy && (r_idx == 5'd0);
    assign o_rem  = reduced[7:0];

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = 5'd31;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = reduced[7:0];
            n_idx = r_idx - 5'd1;
            if (r_idx == 5'd0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
        r_rem <= n_rem;
    end

endmodule
`default_nettype wire

// ===== rtl/video_frame_timecode_cadence_top.sv =====
`default_nettype none
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata[0] frame_done
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: slot, vitc, ltc, audio, tick, frame
// cfg       in         i_cfg_we (no wait)            i_cfg_index, i_cfg_data
//
// One request per cycle while s_axis_tready is high; each result is registered.
// The timecode is a ripple chain of four BCD-pair cells advanced in the same cycle.
// A source_frames write starts a remainder pass over the dividend bits; s_axis_tready
// is low while r_recalc or the pass is busy. After reset all counters read zero.
// A skid entry behind the output register takes one more request while m_axis
// stalls; after that s_axis_tready stays low until the output register drains.
module video_frame_timecode_cadence_top
    import vftc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,  // [0] frame_done
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // [7:0] source_slot, [37:8] vitc_timecode, [67:38] ltc_timecode,
    // [81:68] audio_bytes, [113:82] tick, [145:114] frame_number
    output logic [OUT_BITS-1:0]      m_axis_tdata,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [8:0]          i_cfg_data
);

    logic [2:0]          r_video_mode;
    logic [1:0]          r_tc_select;
    logic [8:0]          r_source_frames;
    logic                r_recalc;
    logic [31:0]         r_count;
    logic [7:0]          r_slot;
    logic [7:0]          r_resid;
    logic [2:0]          r_phase;
    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_out_data;
    logic                r_skid_valid;
    logic [OUT_BITS-1:0] r_skid_data;

    logic [31:0]         n_count;
    logic [7:0]          n_slot;
    logic [7:0]          n_resid;
    logic [2:0]          n_phase;

    logic                accept;
    logic                capture;
    logic                wrap;
    logic                take_out;
    logic [8:0]          depth;
    logic [8:0]          resid_inc;
    logic                mod_busy;
    logic                mod_done;
    logic [7:0]          mod_rem;
    logic [TC_CELLS:0]   carry;
    t_bcd_pair           tc_next [TC_CELLS];
    logic [31:0]         timecode;
    logic [29:0]         vitc;
    logic [29:0]         ltc;
    logic [13:0]         audio;
    logic [OUT_BITS-1:0] result;

    assign s_axis_tready = !mod_busy && !r_recalc && !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign capture       = accept && s_axis_tdata[0];
    assign wrap          = &r_count;
    assign take_out      = r_out_valid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        if (r_source_frames == 9'd0) begin
            depth = 9'd1;
        end else if (r_source_frames > 9'(RING_DEPTH)) begin
            depth = 9'(RING_DEPTH);
        end else begin
            depth = r_source_frames;
        end
    end

    vftc_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_recalc),
        .i_dividend (r_count),
        .i_depth    (depth),
        .o_busy     (mod_busy),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign carry[0] = capture;

    for (genvar k = 0; k < TC_CELLS; k++) begin : g_cell
        t_cell_ctl ctl;
        assign ctl.clear = capture && wrap;
        assign ctl.inc   = carry[k];
        vftc_tc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_max   (TC_CELL_MAX[k]),
            .o_carry (carry[k+1]),
            .o_next  (tc_next[k])
        );
    end

    assign timecode = {tc_next[3], tc_next[2], tc_next[1], tc_next[0]};

    assign resid_inc = {1'b0, r_resid} + 9'd1;

    always_comb begin
        n_count = r_count;
        n_slot  = r_slot;
        n_resid = r_resid;
        n_phase = r_phase;
        if (mod_done) begin
            n_resid = mod_rem;
        end
        if (capture) begin
            n_count = r_count + 32'd1;
            n_slot  = r_resid;
            if (wrap) begin
                n_resid = '0;
                n_phase = '0;
            end else begin
                n_resid = (resid_inc == depth) ? 8'd0 : resid_inc[7:0];
                n_phase = (r_phase == 3'd4) ? 3'd0 : r_phase + 3'd1;
            end
        end
    end

    assign vitc   = (r_tc_select == QUAL_LTC_ONLY)  ? 30'd0 : timecode[29:0];
    assign ltc    = (r_tc_select == QUAL_VITC_ONLY) ? 30'd0 : timecode[29:0];
    assign audio  = vftc_audio_bytes(r_video_mode, n_phase);
    assign result = {6'd0, n_count, n_count[30:0], 1'b0, audio, ltc, vitc, n_slot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_mode    <= '0;
            r_tc_select     <= '0;
            r_source_frames <= 9'd1;
            r_recalc        <= 1'b0;
            r_count         <= '0;
            r_slot          <= '0;
            r_resid         <= '0;
            r_phase         <= '0;
            r_out_valid     <= 1'b0;
            r_skid_valid    <= 1'b0;
        end else begin
            r_recalc <= i_cfg_we && (i_cfg_index == CFG_SOURCE_FRAMES);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_VIDEO_MODE:    r_video_mode    <= i_cfg_data[2:0];
                    CFG_TC_SELECT:     r_tc_select     <= i_cfg_data[1:0];
                    CFG_SOURCE_FRAMES: r_source_frames <= i_cfg_data;
                    default: ;
                endcase
            end
            r_count <= n_count;
            r_slot  <= n_slot;
            r_resid <= n_resid;
            r_phase <= n_phase;
            if (!r_out_valid || take_out) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= accept;
                end
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take_out) begin
            r_out_data <= r_skid_valid ? r_skid_data : result;
        end
        if (accept && r_out_valid && !take_out) begin
            r_skid_data <= result;
        end
    end

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        capture |=> (r_count == $past(r_count) + 32'd1))
        else $error("frame count did not advance on capture");

    a_resid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_recalc && !mod_busy) |-> ({1'b0, r_resid} < depth))
        else $error("ring residue out of range");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= 3'd4)
        else $error("cadence phase out of range");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

endmodule
`default_nettype wire

// ===== sim/vftc_checker.sv =====
`timescale 1ns / 1ps
module vftc_checker
    import vftc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [OUT_BITS-1:0] m_axis_tdata,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [8:0]          i_cfg_data,
    output int                  o_pending,
    output int                  o_errors
);

    // lowest field last, so source_slot lands in the low bits
    typedef struct packed {
        logic [31:0] frame_number;
        logic [31:0] tick;
        logic [13:0] audio_bytes;
        logic [29:0] ltc_timecode;
        logic [29:0] vitc_timecode;
        logic [7:0]  source_slot;
    } t_frame_status;

    localparam int unsigned FRAMES_PER_SEC  = 25;
    localparam int unsigned FRAMES_PER_MIN  = 60 * FRAMES_PER_SEC;
    localparam int unsigned FRAMES_PER_HOUR = 60 * FRAMES_PER_MIN;
    localparam int unsigned FRAMES_PER_DAY  = 24 * FRAMES_PER_HOUR;

    logic [2:0]      video_mode;
    logic [1:0]      tc_select;
    logic [8:0]      source_frames;
    logic [31:0]     frames_captured;
    logic [7:0]      last_slot;
    t_frame_status   status_q[$];
    int              errors = 0;

    assign o_errors = errors;

    function automatic logic [7:0] bcd_pair(input int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic logic [29:0] timecode_of(input logic [31:0] count);
        int unsigned t;
        logic [31:0] tc;
        t  = count % FRAMES_PER_DAY;
        tc = {bcd_pair(t / FRAMES_PER_HOUR),
              bcd_pair((t % FRAMES_PER_HOUR) / FRAMES_PER_MIN),
              bcd_pair((t % FRAMES_PER_MIN) / FRAMES_PER_SEC),
              bcd_pair(t % FRAMES_PER_SEC)};
        return tc[29:0];
    endfunction

    function automatic logic [13:0] audio_bytes_for(input logic [2:0] mode,
                                                    input logic [31:0] count);
        int unsigned phase;
        int unsigned samples;
        phase = count % 5;
        case (mode)
            MODE_NTSC, MODE_1080I2997: begin
                samples = (phase == 0) ? 1600 : 1602;
            end
            MODE_1080I30: begin
                samples = 1600;
            end
            MODE_720P50: begin
                samples = 960;
            end
            MODE_720P5994: begin
                samples = (phase == 0 || phase == 2) ? 802 : 800;
            end
            MODE_720P60: begin
                samples = 800;
            end
            default: begin
                samples = 1920;
            end
        endcase
        return 14'(samples * 8);
    endfunction

    always @(posedge i_clk) begin
        int unsigned   depth;
        logic [29:0]   tc;
        t_frame_status want;
        t_frame_status got;
        if (!i_rst_n) begin
            video_mode      = MODE_PAL;
            tc_select       = 2'd0;
            source_frames   = 9'd1;
            frames_captured = '0;
            last_slot       = '0;
            status_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_VIDEO_MODE:    video_mode    = i_cfg_data[2:0];
                    CFG_TC_SELECT:     tc_select     = i_cfg_data[1:0];
                    CFG_SOURCE_FRAMES: source_frames = i_cfg_data;
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tdata[0]) begin
                    // empty ring acts as one slot, oversized ring is clamped
                    if (source_frames == 0)
                        depth = 1;
                    else if (source_frames > RING_DEPTH)
                        depth = RING_DEPTH;
                    else
                        depth = source_frames;
                    last_slot       = 8'(frames_captured % depth);
                    frames_captured = frames_captured + 32'd1;
                end
                tc = timecode_of(frames_captured);
                want.source_slot   = last_slot;
                want.vitc_timecode = (tc_select == QUAL_LTC_ONLY)  ? '0 : tc;
                want.ltc_timecode  = (tc_select == QUAL_VITC_ONLY) ? '0 : tc;
                want.audio_bytes   = audio_bytes_for(video_mode, frames_captured);
                want.tick          = frames_captured << 1;
                want.frame_number  = frames_captured;
                status_q.push_back(want);
            end

            if (m_axis_tvalid && m_axis_tready) begin
                got = t_frame_status'(m_axis_tdata[$bits(t_frame_status)-1:0]);
                if (status_q.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result: %h", got);
                    errors++;
                end else begin
                    want = status_q.pop_front();
                    if (got !== want) begin
                        if (errors < 10)
                            $display({"mismatch (exp/got): slot %0d/%0d vitc %h/%h ",
                                      "ltc %h/%h audio %0d/%0d tick %h/%h frame %0d/%0d"},
                                     want.source_slot, got.source_slot,
                                     want.vitc_timecode, got.vitc_timecode,
                                     want.ltc_timecode, got.ltc_timecode,
                                     want.audio_bytes, got.audio_bytes,
                                     want.tick, got.tick,
                                     want.frame_number, got.frame_number);
                        errors++;
                    end
                end
            end
            o_pending <= status_q.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import vftc_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_BITS-1:0] m_axis_tdata;
    logic                i_cfg_we;
    logic [1:0]          i_cfg_index;
    logic [8:0]          i_cfg_data;

    int pending;
    int err_count;
    bit idle_on = 1'b1;
    int requests_sent = 0;

    video_frame_timecode_cadence_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    vftc_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending),
        .o_errors      (err_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // result-side backpressure
    initial begin
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    task automatic send_request(input logic frame_done);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, frame_done};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        requests_sent++;
    endtask

    task automatic wait_all_results;
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic load_registers(input logic [2:0] mode, input logic [1:0] quality,
                                  input logic [8:0] frames);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_VIDEO_MODE;
        i_cfg_data  <= {6'd0, mode};
        @(posedge i_clk);
        i_cfg_index <= CFG_TC_SELECT;
        i_cfg_data  <= {7'd0, quality};
        @(posedge i_clk);
        i_cfg_index <= CFG_SOURCE_FRAMES;
        i_cfg_data  <= frames;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_setting(input logic [2:0] mode, input logic [1:0] quality,
                               input logic [8:0] frames, input int count);
        wait_all_results();
        load_registers(mode, quality, frames);
        for (int k = 0; k < count; k++)
            send_request(k % 3 != 2);
    endtask

    initial begin
        logic [2:0] mode;
        logic [1:0] quality;
        logic [8:0] frames;
        int         count;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_VIDEO_MODE;
        i_cfg_data    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: status before any capture, then two captures, then status again
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b1);
        send_request(1'b0);

        run_setting(MODE_NTSC,      QUAL_LTC_ONLY,  9'd0,   3);
        run_setting(MODE_1080I25,   QUAL_VITC_ONLY, 9'd256, 3);
        run_setting(MODE_1080I2997, 2'd3,           9'd511, 3);
        run_setting(MODE_1080I30,   2'd0,           9'd257, 2);
        run_setting(MODE_720P50,    QUAL_LTC_ONLY,  9'd3,   2);
        run_setting(MODE_720P5994,  QUAL_VITC_ONLY, 9'd5,   4);
        run_setting(MODE_720P60,    2'd0,           9'd2,   2);

        while (requests_sent < 530) begin
            if (requests_sent > 450)
                idle_on = 1'b0;
            mode    = 3'($urandom_range(0, 7));
            quality = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
                0:       frames = 9'd0;
                1:       frames = 9'($urandom_range(257, 511));
                2:       frames = 9'd256;
                default: frames = 9'($urandom_range(1, 12));
            endcase
            count = $urandom_range(8, 48);
            wait_all_results();
            load_registers(mode, quality, frames);
            for (int k = 0; k < count; k++)
                send_request($urandom_range(0, 99) < 85);
        end

        wait_all_results();
        repeat (8) @(posedge i_clk);
        if (err_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
